[rtl/core/assert_macros.svh]
// Assertion macros for the WAV stream writer RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/wps_pkg.sv]
// Shared types and constants for the WAV PCM stream writer.
// No dependencies.
`timescale 1ns / 1ps

package wps_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 16777216;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_RATE     = 2'd1;
  localparam logic [1:0] REG_DEPTH    = 2'd2;
  localparam logic [1:0] REG_FRAMES   = 2'd3;

  localparam logic [1:0] DEPTH_U8  = 2'd0;
  localparam logic [1:0] DEPTH_S16 = 2'd1;
  localparam logic [1:0] DEPTH_S24 = 2'd2;
  localparam logic [1:0] DEPTH_F32 = 2'd3;

  localparam logic [3:0]  RST_CHANNELS = 4'd2;
  localparam logic [18:0] RST_RATE     = 19'd48000;
  localparam logic [1:0]  RST_DEPTH    = DEPTH_S16;
  localparam logic [24:0] RST_FRAMES   = 25'd0;

  // Four-character tags, first character in the low byte.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [5:0] HDR_LEN_PCM   = 6'd44;
  localparam logic [5:0] HDR_LEN_FLOAT = 6'd46;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [31:0] FMT_SIZE_PCM   = 32'd16;
  localparam logic [31:0] FMT_SIZE_FLOAT = 32'd18;

  localparam logic [23:0] SCALE_S16 = 24'd32767;
  localparam logic [23:0] SCALE_S24 = 24'd8388607;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        start_of_file;
  } sample_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } stream_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [18:0] sample_rate;
    logic [1:0]  depth_code;
    logic [24:0] frame_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] riff_size;
    logic [31:0] data_size;
    logic [31:0] byte_rate;
    logic [5:0]  block_align;
    logic [5:0]  bits;
  } hdr_t;

  // Converted sample waiting for the serializer.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  last_idx;
    logic        sof;
  } job_t;

endpackage

[rtl/core/wps_regs.sv]
// Configuration registers behind the APB-style port, plus registered header fields.
// Depends on wps_pkg.
`timescale 1ns / 1ps

module wps_regs #(
  parameter int unsigned MAX_FRAMES = wps_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output wps_pkg::cfg_t              cfg,
  output wps_pkg::hdr_t              hdr
);
  import wps_pkg::*;

  logic [1:0]  reg_idx;
  logic        wr;
  logic [24:0] frames_sat;
  logic [2:0]  bytes_per;
  logic [6:0]  block_w;
  logic [30:0] data_w;
  logic [24:0] rate_w;

  assign reg_idx = paddr[3:2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= RST_CHANNELS;
      cfg.sample_rate   <= RST_RATE;
      cfg.depth_code    <= RST_DEPTH;
      cfg.frame_count   <= RST_FRAMES;
    end else if (wr) begin
      unique case (reg_idx)
        REG_CHANNELS: cfg.channel_count <= pwdata[3:0];
        REG_RATE:     cfg.sample_rate   <= pwdata[18:0];
        REG_DEPTH:    cfg.depth_code    <= pwdata[1:0];
        REG_FRAMES:   cfg.frame_count   <= pwdata[24:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNELS: prdata = {28'd0, cfg.channel_count};
      REG_RATE:     prdata = {13'd0, cfg.sample_rate};
      REG_DEPTH:    prdata = {30'd0, cfg.depth_code};
      REG_FRAMES:   prdata = {7'd0, cfg.frame_count};
      default:      prdata = 32'd0;
    endcase
  end

  // Header size fields: products in the first stage, RIFF size in the second.
  assign frames_sat = (cfg.frame_count > 25'(MAX_FRAMES)) ? 25'(MAX_FRAMES) : cfg.frame_count;
  assign bytes_per  = {1'b0, cfg.depth_code} + 3'd1;
  assign block_w    = 7'(cfg.channel_count) * 7'(bytes_per);
  assign data_w     = 31'(frames_sat) * 31'(block_w[5:0]);
  assign rate_w     = 25'(cfg.sample_rate) * 25'(block_w[5:0]);

  always_ff @(posedge clk) begin
    hdr.data_size   <= 32'(data_w);
    hdr.byte_rate   <= 32'(rate_w);
    hdr.block_align <= block_w[5:0];
    hdr.bits        <= {bytes_per, 3'b000};
    hdr.riff_size   <= hdr.data_size
                       + ((cfg.depth_code == DEPTH_F32) ? 32'd38 : 32'd36);
  end

endmodule

[rtl/core/wps_conv.sv]
// Input register and float-to-PCM sample conversion.
// Depends on wps_pkg.
`timescale 1ns / 1ps

module wps_conv (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  wps_pkg::sample_t sample_data,
  input  logic [1:0]       depth_code,
  output logic             job_valid,
  output wps_pkg::job_t    job,
  input  logic             job_take
);
  import wps_pkg::*;

  logic        full;
  sample_t     item;

  logic        neg;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic        is_nan;
  logic        is_sat;
  logic        is_zero;
  logic [23:0] mant;
  logic [7:0]  sh;
  logic [4:0]  kshift;
  logic [46:0] mant_w;
  logic [46:0] prod;
  logic [46:0] quo;
  logic        rem_nz;
  logic [23:0] mag;
  logic [23:0] sval;
  logic [7:0]  ubyte;

  assign sample_ready = !full || job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      full <= 1'b1;
    end else if (job_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      item <= sample_data;
    end
  end

  // Classify the float: NaN and zero give zero, |s| >= 1 saturates.
  always_comb begin
    neg    = item.sample_bits[31];
    expo   = item.sample_bits[30:23];
    frac   = item.sample_bits[22:0];
    is_nan = (expo == 8'hFF) && (frac != 23'd0);
    is_sat = !is_nan && (expo >= 8'd127);
    if (expo == 8'd0) begin
      mant = {1'b0, frac};
      sh   = 8'd149;
    end else begin
      mant = {1'b1, frac};
      sh   = 8'd150 - expo;
    end
    is_zero = is_nan || (!is_sat && (mant == 24'd0));
  end

  // Scales are all 2^n - 1, so the product is a shift and a subtract.
  always_comb begin
    case (depth_code)
      DEPTH_U8:  kshift = 5'd7;
      DEPTH_S16: kshift = 5'd15;
      default:   kshift = 5'd23;
    endcase
    mant_w = 47'(mant);
    prod   = (mant_w << kshift) - mant_w;
    quo    = (sh >= 8'd47) ? 47'd0 : (prod >> sh[5:0]);
    rem_nz = (prod != (quo << sh[5:0]));
  end

  always_comb begin
    if (is_sat) begin
      mag = (depth_code == DEPTH_S16) ? SCALE_S16 : SCALE_S24;
    end else if (is_zero) begin
      mag = 24'd0;
    end else begin
      mag = quo[23:0];
    end
    sval = neg ? (24'd0 - mag) : mag;

    if (is_zero) begin
      ubyte = 8'd128;
    end else if (is_sat) begin
      ubyte = neg ? 8'd1 : 8'd255;
    end else if (neg) begin
      ubyte = 8'd128 - quo[7:0] - {7'd0, rem_nz};
    end else begin
      ubyte = 8'd128 + quo[7:0];
    end
  end

  always_comb begin
    job_valid    = full;
    job.sof      = item.start_of_file;
    job.last_idx = depth_code;
    case (depth_code)
      DEPTH_U8:  job.word = {24'd0, ubyte};
      DEPTH_F32: job.word = is_nan ? 32'd0 : item.sample_bits;
      default:   job.word = {8'd0, sval};
    endcase
  end

endmodule

[rtl/core/wps_ser.sv]
// Byte serializer: walks the WAV header and the converted sample bytes.
// Depends on wps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wps_ser (
  input  logic             clk,
  input  logic             rst,
  input  wps_pkg::cfg_t    cfg,
  input  wps_pkg::hdr_t    hdr,
  input  logic             conv_valid,
  input  wps_pkg::job_t    conv_job,
  output logic             job_take,
  output logic             stream_valid,
  input  logic             stream_ready,
  output wps_pkg::stream_t stream_data
);
  import wps_pkg::*;

  logic        job_valid;
  job_t        job;
  logic        in_hdr;
  logic [5:0]  idx;

  logic        is_float;
  logic [5:0]  hlen;
  logic [5:0]  hidx;
  logic        ext_zero;
  logic [31:0] hdr_word;
  logic [7:0]  hdr_byte;
  logic        fire;
  logic        last_hdr;
  logic        last_smp;

  assign is_float = (cfg.depth_code == DEPTH_F32);
  assign hlen     = is_float ? HDR_LEN_FLOAT : HDR_LEN_PCM;

  // Float header carries a two-byte extension size after bits-per-sample.
  always_comb begin
    hidx     = idx;
    ext_zero = 1'b0;
    if (is_float && (idx >= 6'd36)) begin
      if (idx < 6'd38) begin
        ext_zero = 1'b1;
      end else begin
        hidx = idx - 6'd2;
      end
    end
  end

  always_comb begin
    unique case (hidx[5:2])
      4'd0:    hdr_word = TAG_RIFF;
      4'd1:    hdr_word = hdr.riff_size;
      4'd2:    hdr_word = TAG_WAVE;
      4'd3:    hdr_word = TAG_FMT;
      4'd4:    hdr_word = is_float ? FMT_SIZE_FLOAT : FMT_SIZE_PCM;
      4'd5:    hdr_word = {12'd0, cfg.channel_count, (is_float ? FMT_FLOAT : FMT_PCM)};
      4'd6:    hdr_word = {13'd0, cfg.sample_rate};
      4'd7:    hdr_word = hdr.byte_rate;
      4'd8:    hdr_word = {10'd0, hdr.bits, 10'd0, hdr.block_align};
      4'd9:    hdr_word = TAG_DATA;
      4'd10:   hdr_word = hdr.data_size;
      default: hdr_word = 32'd0;
    endcase
    hdr_byte = ext_zero ? 8'h00 : hdr_word[{hidx[1:0], 3'b000} +: 8];
  end

  assign fire     = job_valid && stream_ready;
  assign last_hdr = in_hdr && (idx == (hlen - 6'd1));
  assign last_smp = !in_hdr && (idx[1:0] == job.last_idx);
  assign job_take = !job_valid || (fire && last_smp);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      in_hdr    <= 1'b0;
      idx       <= 6'd0;
    end else if (job_take) begin
      job_valid <= conv_valid;
      in_hdr    <= conv_valid && conv_job.sof;
      idx       <= 6'd0;
    end else if (fire) begin
      if (last_hdr) begin
        in_hdr <= 1'b0;
        idx    <= 6'd0;
      end else begin
        idx <= idx + 6'd1;
      end
    end
  end

  // Load the next transaction the same edge the last byte leaves.
  always_ff @(posedge clk) begin
    if (job_take && conv_valid) begin
      job <= conv_job;
    end
  end

  assign stream_valid          = job_valid;
  assign stream_data.data_byte = in_hdr ? hdr_byte : job.word[{idx[1:0], 3'b000} +: 8];
  assign stream_data.last_byte = last_smp;

  `ASSERT_IMPLIES(a_hdr_needs_sof, clk, rst, job_valid && in_hdr, job.sof)
  `ASSERT_IMPLIES(a_hdr_idx_range, clk, rst, job_valid && in_hdr, idx < hlen)
  `ASSERT_IMPLIES(a_smp_idx_range, clk, rst, job_valid && !in_hdr, idx <= 6'(job.last_idx))
  `ASSERT_NEXT(a_stall_holds_idx, clk, rst, job_valid && !stream_ready, job_valid && $stable(idx))

endmodule

[rtl/core/wav_pcm_stream_writer_unit.sv]
// Top level of the WAV PCM stream writer: config port, converter, serializer.
// Depends on wps_pkg, wps_regs, wps_conv and wps_ser.
`timescale 1ns / 1ps

// Turns single-precision float samples into a little-endian RIFF/WAVE byte
// stream, one byte per cycle on the stream port while stream_ready is high.
// An item gives depth_code + 1 sample bytes (1 to 4), plus 44 header bytes
// (46 for float) when start_of_file is set; the byte-wide output port bounds
// the sustained item rate. The input register and the converter take the
// next item while the serializer still sends the previous one, and an item's
// first byte leaves after the input register and the serializer's job register.
// Header size fields are registered from the configuration registers, with the
// RIFF size one register further on; registers are read and written over the
// APB-style port at byte addresses 0, 4, 8 and 12.
module wav_pcm_stream_writer_unit #(
  parameter int unsigned MAX_FRAMES = wps_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  wps_pkg::sample_t           sample_data,
  output logic                       stream_valid,
  input  logic                       stream_ready,
  output wps_pkg::stream_t           stream_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wps_pkg::*;

  cfg_t cfg;
  hdr_t hdr;
  logic conv_valid;
  job_t conv_job;
  logic job_take;

  assign pready = 1'b1;

  wps_regs #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg),
    .hdr    (hdr)
  );

  wps_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_data (sample_data),
    .depth_code  (cfg.depth_code),
    .job_valid   (conv_valid),
    .job         (conv_job),
    .job_take    (job_take)
  );

  wps_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hdr         (hdr),
    .conv_valid  (conv_valid),
    .conv_job    (conv_job),
    .job_take    (job_take),
    .stream_valid(stream_valid),
    .stream_ready(stream_ready),
    .stream_data (stream_data)
  );

endmodule
